FILE: design/assert_macros.svh
// Assertion macros used by the top-level design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Same-cycle implication under synchronous reset.
`define TWND_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication under synchronous reset.
`define TWND_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`endif

FILE: design/twnd_pkg.sv
// Types, constants and the 2^-x table of the wrapped normal density block.
package twnd_pkg;

   localparam int MAX_WRAP        = 7;
   localparam int EXP_TABLE_DEPTH = 256;
   localparam int EXP_IDX_W       = $clog2(EXP_TABLE_DEPTH);
   localparam int SERIES_TERMS    = 12;

   localparam logic [15:0] TWO_PI_Q13 = 16'd51472;
   localparam logic [30:0] LOG2E_Q30  = 31'd1549082005;
   localparam logic [31:0] LN2_Q32    = 32'd2977044472;
   localparam logic [40:0] TERM_CAP   = 41'h100_0000_0000;

   typedef enum logic [2:0] {
      CSR_MEAN_X     = 3'd0,
      CSR_MEAN_Y     = 3'd1,
      CSR_PREC_XX    = 3'd2,
      CSR_PREC_XY    = 3'd3,
      CSR_PREC_YY    = 3'd4,
      CSR_NORM_GAIN  = 3'd5,
      CSR_WRAP_COUNT = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic [15:0] angle_x;
      logic [15:0] angle_y;
   } req_type;

   typedef struct packed {
      logic [31:0] density;
      logic        saturated;
   } rsp_type;

   // valid and last-term mark that ride along with each term
   typedef struct packed {
      logic valid;
      logic last;
   } term_tag_type;

   typedef logic [32:0] pow2_rom_type [EXP_TABLE_DEPTH];

   // 2^(-i/DEPTH) in Q32 by a truncated series of exp(-g)
   function automatic pow2_rom_type build_pow2_rom();
      pow2_rom_type       rom;
      logic [63:0]        g;
      logic [63:0]        t;
      logic signed [63:0] acc;
      for (int i = 0; i < EXP_TABLE_DEPTH; i++) begin
         g   = (64'(i) * 64'(LN2_Q32)) / EXP_TABLE_DEPTH;
         t   = 64'h1_0000_0000;
         acc = 64'sh1_0000_0000;
         for (int k = 1; k <= SERIES_TERMS; k++) begin
            t = ((t * g) >> 32) / 64'(k);
            if (k % 2 == 1) begin
               acc = acc - $signed(t);
            end else begin
               acc = acc + $signed(t);
            end
         end
         rom[i] = acc[32:0];
      end
      return rom;
   endfunction

   localparam pow2_rom_type POW2_ROM = build_pow2_rom();

endpackage

FILE: design/twnd_quad.sv
// Offset and quadratic form pipeline: four stages from wrap offsets to q in Q29.
module twnd_quad import twnd_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  term_tag_type        tag_in,
   input  logic [15:0]         angle_x,
   input  logic [15:0]         angle_y,
   input  logic signed [3:0]   wrap_j,
   input  logic signed [3:0]   wrap_k,
   input  logic [15:0]         mean_x,
   input  logic [15:0]         mean_y,
   input  logic signed [31:0]  prec_xx,
   input  logic signed [31:0]  prec_xy,
   input  logic signed [31:0]  prec_yy,
   output term_tag_type        tag_out,
   output logic signed [62:0]  q_out
);

   term_tag_type       tag_a_ff, tag_b_ff, tag_c_ff, tag_d_ff;
   logic signed [20:0] x_ff, y_ff, x_in, y_in;
   logic signed [28:0] xx_ff, xy_ff, yy_ff;
   logic signed [41:0] xx_full, xy_full, yy_full;
   logic signed [60:0] p0_ff, p1_ff, p2_ff;
   logic signed [62:0] q_ff, q_in;

   always_comb begin
      x_in = $signed({5'b0, angle_x})
           + $signed({{17{wrap_j[3]}}, wrap_j}) * $signed({5'b0, TWO_PI_Q13})
           - $signed({5'b0, mean_x});
      y_in = $signed({5'b0, angle_y})
           + $signed({{17{wrap_k[3]}}, wrap_k}) * $signed({5'b0, TWO_PI_Q13})
           - $signed({5'b0, mean_y});
      xx_full = x_ff * x_ff;
      xy_full = x_ff * y_ff;
      yy_full = y_ff * y_ff;
      q_in = 63'(p0_ff) + (63'(p1_ff) <<< 1) + 63'(p2_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_a_ff <= '0;
         tag_b_ff <= '0;
         tag_c_ff <= '0;
         tag_d_ff <= '0;
      end else begin
         tag_a_ff <= tag_in;
         tag_b_ff <= tag_a_ff;
         tag_c_ff <= tag_b_ff;
         tag_d_ff <= tag_c_ff;
      end
      x_ff  <= x_in;
      y_ff  <= y_in;
      // floor to 13 fraction bits (Q16.13)
      xx_ff <= xx_full[41:13];
      xy_ff <= xy_full[41:13];
      yy_ff <= yy_full[41:13];
      p0_ff <= xx_ff * prec_xx;
      p1_ff <= xy_ff * prec_xy;
      p2_ff <= yy_ff * prec_yy;
      q_ff  <= q_in;
   end

   assign tag_out = tag_d_ff;
   assign q_out   = q_ff;

endmodule

FILE: design/twnd_exp.sv
// exp(-q/2) pipeline: range check, log2 e scaling, table lookup, correction, shift.
module twnd_exp import twnd_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  term_tag_type       tag_in,
   input  logic signed [62:0] q_in,
   output term_tag_type       tag_out,
   output logic [40:0]        term_out
);

   term_tag_type       tag_e_ff, tag_f_ff, tag_g_ff, tag_h_ff, tag_i_ff;
   logic signed [56:0] h_full;
   logic signed [31:0] h_ff;
   logic               zero_e_ff, cap_e_ff, zero_f_ff, cap_f_ff;
   logic               zero_g_ff, cap_g_ff, zero_h_ff, cap_h_ff;
   logic signed [63:0] u_full;
   logic signed [31:0] u_ff;
   logic signed [7:0]  ip_g_ff, ip_h_ff;
   logic [EXP_IDX_W-1:0] idx;
   logic [23-EXP_IDX_W:0] frac_lo;
   logic [55:0]        d_full;
   logic [32:0]        base_ff;
   logic [31:0]        d_ff;
   logic [64:0]        bd_full;
   logic [32:0]        v_ff, v_in;
   logic [3:0]         neg_ip;
   logic [41:0]        shl;
   logic [40:0]        term_ff, term_in;

   always_comb begin
      h_full  = 57'(q_in >>> 6);
      u_full  = h_ff * $signed({1'b0, LOG2E_Q30});
      idx     = u_ff[23 -: EXP_IDX_W];
      frac_lo = u_ff[23-EXP_IDX_W:0];
      d_full  = (24+32)'(frac_lo) * (24+32)'(LN2_Q32);
      bd_full = 65'(base_ff) * 65'(d_ff);
      v_in    = base_ff - bd_full[64:32];
      neg_ip  = 4'(-ip_h_ff);
      shl     = 42'(v_ff) << neg_ip;
      if (zero_h_ff) begin
         term_in = '0;
      end else if (cap_h_ff) begin
         term_in = TERM_CAP;
      end else if (!ip_h_ff[7]) begin
         term_in = (ip_h_ff >= 8'sd40) ? '0 : 41'(v_ff >> ip_h_ff[5:0]);
      end else if (ip_h_ff < -8'sd9 || shl > 42'(TERM_CAP)) begin
         term_in = TERM_CAP;
      end else begin
         term_in = shl[40:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_e_ff <= '0;
         tag_f_ff <= '0;
         tag_g_ff <= '0;
         tag_h_ff <= '0;
         tag_i_ff <= '0;
      end else begin
         tag_e_ff <= tag_in;
         tag_f_ff <= tag_e_ff;
         tag_g_ff <= tag_f_ff;
         tag_h_ff <= tag_g_ff;
         tag_i_ff <= tag_h_ff;
      end
      // negligible or growing terms skip the table
      zero_e_ff <= h_full >= 57'sd1073741824;
      cap_e_ff  <= h_full < -57'sd100663296;
      h_ff      <= h_full[31:0];
      zero_f_ff <= zero_e_ff;
      cap_f_ff  <= cap_e_ff;
      u_ff      <= u_full[61:30];
      zero_g_ff <= zero_f_ff;
      cap_g_ff  <= cap_f_ff;
      ip_g_ff   <= u_ff[31:24];
      base_ff   <= POW2_ROM[idx];
      d_ff      <= d_full[55:24];
      zero_h_ff <= zero_g_ff;
      cap_h_ff  <= cap_g_ff;
      ip_h_ff   <= ip_g_ff;
      v_ff      <= v_in;
      term_ff   <= term_in;
   end

   assign tag_out  = tag_i_ff;
   assign term_out = term_ff;

endmodule

FILE: design/toroidal_wrapped_normal_density.sv
// Top level: registers, wrap offset sequencer, term sum and gain scaling.
// Usage:
// A word on req_data (two Q3.13 angles) is taken when req_valid is high and
// req_stall is low. The block then runs every wrap offset pair (j,k) in -n..n
// through a pipelined term unit, one term per cycle, adds the terms, scales
// the sum by norm_gain and puts the Q8.24 density and its saturation flag on
// rsp_data with rsp_valid.
// One item is worked at a time: req_stall stays high from acceptance until
// the result reaches the output register; the single term pipeline works
// (2n+1)^2 terms per item (nine terms at n = 1). A new word is taken while a
// finished result still waits on rsp.
// When rsp_stall is high the result holds in the output register; a
// following result waits in the scaling stage and the block takes nothing.
// Registers must be written through csr_we / csr_index / csr_wdata only while
// idle; the block has no guard for this. Synchronous reset clears all control
// state and loads the register defaults (unit precision, wrap count one).
`include "assert_macros.svh"
module toroidal_wrapped_normal_density import twnd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   logic [15:0]        mean_x_ff, mean_y_ff;
   logic signed [31:0] prec_xx_ff, prec_xy_ff, prec_yy_ff;
   logic [31:0]        norm_gain_ff;
   logic [2:0]         wrap_count_ff;

   logic               busy_ff, busy_in;
   logic               active_ff, active_in;
   req_type            point_ff;
   logic signed [3:0]  n_ff, j_ff, k_ff, n_in, j_in, k_in;
   term_tag_type       seq_tag;
   term_tag_type       quad_tag, exp_tag;
   logic signed [62:0] q;
   logic [40:0]        term;
   logic [47:0]        acc_ff, acc_in, sum;
   logic               fin_valid_ff;
   logic [47:0]        fin_ff;
   logic               sc_valid_ff, sc_valid_in;
   logic [47:0]        hi_prod_ff;
   logic [63:0]        lo_prod_ff;
   logic [48:0]        dens;
   logic               rsp_valid_ff, rsp_valid_in, load;
   rsp_type            rsp_ff;
   logic               accept;

   assign accept = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         mean_x_ff     <= '0;
         mean_y_ff     <= '0;
         prec_xx_ff    <= 32'sd65536;
         prec_xy_ff    <= '0;
         prec_yy_ff    <= 32'sd65536;
         norm_gain_ff  <= 32'd2670176;
         wrap_count_ff <= 3'd1;
      end else if (csr_we) begin
         case (csr_index)
            CSR_MEAN_X:     mean_x_ff     <= csr_wdata[15:0];
            CSR_MEAN_Y:     mean_y_ff     <= csr_wdata[15:0];
            CSR_PREC_XX:    prec_xx_ff    <= csr_wdata;
            CSR_PREC_XY:    prec_xy_ff    <= csr_wdata;
            CSR_PREC_YY:    prec_yy_ff    <= csr_wdata;
            CSR_NORM_GAIN:  norm_gain_ff  <= csr_wdata;
            CSR_WRAP_COUNT: wrap_count_ff <= csr_wdata[2:0];
            default: ;
         endcase
      end
   end

   // offset sequencer: k runs fastest
   always_comb begin
      n_in      = n_ff;
      j_in      = j_ff;
      k_in      = k_ff;
      active_in = active_ff;
      seq_tag.valid = active_ff;
      seq_tag.last  = active_ff && (j_ff == n_ff) && (k_ff == n_ff);
      if (accept) begin
         n_in = (32'(wrap_count_ff) > MAX_WRAP) ? 4'(MAX_WRAP)
                                                : $signed({1'b0, wrap_count_ff});
         j_in = -n_in;
         k_in = -n_in;
         active_in = 1'b1;
      end else if (active_ff) begin
         if (seq_tag.last) begin
            active_in = 1'b0;
         end else if (k_ff == n_ff) begin
            k_in = -n_ff;
            j_in = j_ff + 4'sd1;
         end else begin
            k_in = k_ff + 4'sd1;
         end
      end
   end

   twnd_quad u_quad (
      .clock   (clock),
      .reset   (reset),
      .tag_in  (seq_tag),
      .angle_x (point_ff.angle_x),
      .angle_y (point_ff.angle_y),
      .wrap_j  (j_ff),
      .wrap_k  (k_ff),
      .mean_x  (mean_x_ff),
      .mean_y  (mean_y_ff),
      .prec_xx (prec_xx_ff),
      .prec_xy (prec_xy_ff),
      .prec_yy (prec_yy_ff),
      .tag_out (quad_tag),
      .q_out   (q)
   );

   twnd_exp u_exp (
      .clock    (clock),
      .reset    (reset),
      .tag_in   (quad_tag),
      .q_in     (q),
      .tag_out  (exp_tag),
      .term_out (term)
   );

   always_comb begin
      sum    = acc_ff + 48'(term);
      acc_in = acc_ff;
      if (exp_tag.valid) begin
         acc_in = exp_tag.last ? '0 : sum;
      end
      dens = {1'b0, hi_prod_ff} + 49'(lo_prod_ff[63:32]);
      load = sc_valid_ff && (!rsp_valid_ff || !rsp_stall);
      sc_valid_in = fin_valid_ff || (sc_valid_ff && !load);
      rsp_valid_in = load || (rsp_valid_ff && rsp_stall);
      busy_in = accept || (busy_ff && !load);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         active_ff    <= 1'b0;
         acc_ff       <= '0;
         fin_valid_ff <= 1'b0;
         sc_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         active_ff    <= active_in;
         acc_ff       <= acc_in;
         fin_valid_ff <= exp_tag.valid && exp_tag.last;
         sc_valid_ff  <= sc_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      n_ff <= n_in;
      j_ff <= j_in;
      k_ff <= k_in;
      if (accept) begin
         point_ff <= req_data;
      end
      fin_ff <= sum;
      if (fin_valid_ff) begin
         hi_prod_ff <= 48'(fin_ff[47:32]) * 48'(norm_gain_ff);
         lo_prod_ff <= 64'(fin_ff[31:0]) * 64'(norm_gain_ff);
      end
      if (load) begin
         rsp_ff.saturated <= |dens[48:32];
         rsp_ff.density   <= (|dens[48:32]) ? '1 : dens[31:0];
      end
   end

   assign req_stall = busy_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `TWND_ASSERT_NEXT(a_busy_after_accept, clock, reset, accept, req_stall,
      "block not busy after accepting a word")
   `TWND_ASSERT_NOW(a_seq_within_busy, clock, reset, active_ff || fin_valid_ff, busy_ff,
      "terms in flight while idle")
   `TWND_ASSERT_NOW(a_sat_clips, clock, reset, rsp_valid && rsp_data.saturated,
      rsp_data.density == 32'hFFFF_FFFF, "saturated result not clipped")

endmodule

FILE: bench/toroidal_wrapped_normal_density_test.sv
// Testbench of the wrapped normal density block: random and corner words against a local predictor.
`timescale 1ns / 100ps
module toroidal_wrapped_normal_density_test;
   import twnd_pkg::*;

   class density_scoreboard;
      longint unsigned pow2_table [EXP_TABLE_DEPTH];
      longint unsigned mean_x, mean_y, gain;
      longint          pxx, pxy, pyy;
      int unsigned     wraps;
      rsp_type         pending [$];
      int              errors;

      function new();
         longint unsigned g, t;
         longint          acc;
         for (int i = 0; i < EXP_TABLE_DEPTH; i++) begin
            g   = (longint'(i) * 64'd2977044472) / EXP_TABLE_DEPTH;
            t   = 64'h1_0000_0000;
            acc = 64'sh1_0000_0000;
            for (int k = 1; k <= 12; k++) begin
               t = ((t * g) >> 32) / longint'(k);
               if (k % 2 == 1) begin
                  acc -= longint'(t);
               end else begin
                  acc += longint'(t);
               end
            end
            pow2_table[i] = longint'(acc);
         end
         mean_x = 0; mean_y = 0; pxx = 65536; pxy = 0; pyy = 65536;
         gain = 2670176; wraps = 1; errors = 0;
      endfunction

      function void write_reg(csr_index_type idx, logic [31:0] value);
         case (idx)
            CSR_MEAN_X:     mean_x = value[15:0];
            CSR_MEAN_Y:     mean_y = value[15:0];
            CSR_PREC_XX:    pxx = longint'(signed'(value));
            CSR_PREC_XY:    pxy = longint'(signed'(value));
            CSR_PREC_YY:    pyy = longint'(signed'(value));
            CSR_NORM_GAIN:  gain = value;
            CSR_WRAP_COUNT: wraps = value[2:0];
            default: ;
         endcase
      endfunction

      // exp(-q/2), q in Q29, result Q32 held at 256.0
      function longint unsigned gauss_term(longint q);
         longint          h, u, ip;
         longint unsigned f, scaled, idx, r, d, base, v;
         longint unsigned cap;
         cap = 64'h100_0000_0000;
         h = q >>> 6;
         if (h >= (64'sd64 <<< 24)) return 0;
         if (h < -(64'sd6 <<< 24)) return cap;
         u  = (h * 64'sd1549082005) >>> 30;
         ip = u >>> 24;
         f  = u - (ip <<< 24);
         scaled = f * EXP_TABLE_DEPTH;
         idx = scaled >> 24;
         r   = scaled & 64'hFF_FFFF;
         if (idx >= EXP_TABLE_DEPTH) idx = EXP_TABLE_DEPTH - 1;
         d    = (r * 64'd2977044472) / (64'(EXP_TABLE_DEPTH) << 24);
         base = pow2_table[idx];
         v    = base - ((base * d) >> 32);
         if (ip >= 0) begin
            if (ip >= 40) return 0;
            return v >> ip;
         end
         if (-ip > 9) return cap;
         v = v << (-ip);
         return (v > cap) ? cap : v;
      endfunction

      function void note_input(req_type word);
         longint          n, x, y, q;
         longint unsigned sum, dens;
         rsp_type         res;
         n   = (wraps > MAX_WRAP) ? MAX_WRAP : wraps;
         sum = 0;
         for (longint j = -n; j <= n; j++) begin
            for (longint k = -n; k <= n; k++) begin
               x = longint'(word.angle_x) + j * 51472 - longint'(mean_x);
               y = longint'(word.angle_y) + k * 51472 - longint'(mean_y);
               q = ((x * x) >>> 13) * pxx + 2 * ((x * y) >>> 13) * pxy
                   + ((y * y) >>> 13) * pyy;
               sum += gauss_term(q);
            end
         end
         dens = (sum >> 32) * gain + (((sum & 64'hFFFF_FFFF) * gain) >> 32);
         res.saturated = dens > 64'hFFFF_FFFF;
         res.density   = res.saturated ? 32'hFFFF_FFFF : dens[31:0];
         pending.push_back(res);
      endfunction

      function void report(string what);
         $display("mismatch: %s", what);
         errors++;
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         if (pending.size() == 0) begin
            report($sformatf("unexpected word density=%h", got.density));
            return;
         end
         want = pending.pop_front();
         if (got.density !== want.density)
            report($sformatf("density %h, predicted %h", got.density, want.density));
         if (got.saturated !== want.saturated)
            report($sformatf("saturated %b, predicted %b", got.saturated, want.saturated));
      endfunction
   endclass

   logic          clock = 0;
   logic          reset = 1;
   logic          req_valid = 0;
   logic          req_stall;
   req_type       req_data = '0;
   logic          rsp_valid;
   logic          rsp_stall = 0;
   rsp_type       rsp_data;
   logic          csr_we = 0;
   csr_index_type csr_index = CSR_MEAN_X;
   logic [31:0]   csr_wdata = '0;

   density_scoreboard board = new();
   int idle_mode = 0;      // 0 none, 1 sender, 2 receiver, 3 both
   int hold_cycles = 0;

   always #5 clock = ~clock;

   toroidal_wrapped_normal_density dut (.*);

   // receiver: check accepted words, then pick next stall
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) board.check_result(rsp_data);
      if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_stall <= 1;
      end else if (idle_mode == 2) begin
         rsp_stall <= $urandom_range(99) < 74;
      end else if (idle_mode == 3) begin
         rsp_stall <= $urandom_range(99) < 25;
      end else begin
         rsp_stall <= 0;
      end
   end

   task automatic send_word(logic [15:0] ax, logic [15:0] ay);
      int gap;
      req_valid <= 1;
      req_data  <= '{angle_x: ax, angle_y: ay};
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_input('{angle_x: ax, angle_y: ay});
      gap = 0;
      if (idle_mode == 1 && $urandom_range(99) < 74) gap = $urandom_range(1, 12);
      if (idle_mode == 3 && $urandom_range(99) < 25) gap = $urandom_range(1, 12);
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_valid <= 0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   task automatic write_csr(csr_index_type idx, logic [31:0] value);
      csr_we    <= 1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 0;
      board.write_reg(idx, value);
      @(posedge clock);
   endtask

   task automatic random_words(int count);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(9) == 0) begin
            send_word(16'($urandom), 16'($urandom));
         end else begin
            send_word(16'($urandom_range(51471)), 16'($urandom_range(51471)));
         end
      end
   endtask

   initial begin
      int prec_span;
      repeat (10) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // corners at reset settings
      send_word(0, 0);
      send_word(51471, 51471);
      send_word(16'hFFFF, 16'hFFFF);
      send_word(0, 51471);
      send_word(25736, 25736);
      send_word(16'h5555, 16'hAAAA);
      random_words(100);
      drain();

      // negligible terms, zero wraps, largest gain
      write_csr(CSR_MEAN_X, 51471);
      write_csr(CSR_MEAN_Y, 0);
      write_csr(CSR_WRAP_COUNT, 0);
      write_csr(CSR_PREC_XX, 32'h7FFF_FFFF);
      write_csr(CSR_PREC_YY, 32'h0000_1000);
      write_csr(CSR_NORM_GAIN, 32'hFFFF_FFFF);
      idle_mode = 1;
      send_word(51471, 0);
      send_word(0, 0);
      random_words(40);
      drain();

      // indefinite precision, widest wrap: capped terms and saturation
      write_csr(CSR_PREC_XX, 32'h8000_0000);
      write_csr(CSR_PREC_XY, 32'h7FFF_FFFF);
      write_csr(CSR_PREC_YY, 32'h8000_0000);
      write_csr(CSR_WRAP_COUNT, 7);
      idle_mode = 2;
      send_word(0, 0);
      send_word(51471, 51471);
      random_words(6);
      drain();

      // zero gain
      write_csr(CSR_NORM_GAIN, 0);
      write_csr(CSR_WRAP_COUNT, 2);
      write_csr(CSR_PREC_XY, 32'hFFFF_0000);
      idle_mode = 3;
      random_words(20);
      drain();

      // random settings, mixed idling
      for (int phase = 0; phase < 8; phase++) begin
         prec_span = 1 << $urandom_range(14, 21);
         write_csr(CSR_MEAN_X, $urandom_range(51471));
         write_csr(CSR_MEAN_Y, $urandom_range(51471));
         write_csr(CSR_PREC_XX, $urandom_range(prec_span));
         write_csr(CSR_PREC_XY, int'($urandom_range(prec_span)) - prec_span / 2);
         write_csr(CSR_PREC_YY, int'($urandom_range(prec_span)) - prec_span / 8);
         write_csr(CSR_NORM_GAIN, $urandom);
         write_csr(CSR_WRAP_COUNT, $urandom_range(3));
         idle_mode = phase % 4;
         if (phase == 2) hold_cycles = 400;   // back up the block
         random_words(15);
         if (phase == 5) begin
            drain();
         end
         random_words(15);
         drain();
      end

      idle_mode = 0;
      if (board.pending.size() != 0) board.report("results never arrived");
      if (board.errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("CHECK FAILED");
      $finish;
   end
endmodule
